@@ sv/kdb_pkg.sv @@
// Shared types and constants for the k-dependence parent selection block.
package kdb_pkg;

  localparam int AttW   = 5;
  localparam int ScoreW = 32;
  localparam int OutSlots = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 6;

  localparam logic [1:0] OpLoadScore = 2'd0;
  localparam logic [1:0] OpLoadCond  = 2'd1;
  localparam logic [1:0] OpBuild     = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgKParents = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNumAtts  = 2'd1;

  typedef enum logic [3:0] {
    StIdle,
    StRankI,
    StRankIc,
    StRankJ,
    StRankJc,
    StRankW,
    StPickP,
    StPickPc,
    StPickQ,
    StPickQc,
    StPickQu,
    StEmit
  } kdb_state_e;

endpackage

@@ sv/kdb_parent_selection.sv @@
// Load-phase tables and build sequencer for k-dependence parent selection.
// A build ranks the n attributes by score and then searches the parents of
// each in rank order, paced by the single read ports of the score and conditional
// score memories. Results come out as one-cycle strobes spaced by the parent
// search of each attribute; busy_o stays high until the last one.
// Reset clears control state, the configuration and the parent slots; the score tables are undefined until loaded.
module kdb_parent_selection #(
  parameter int MAX_ATTS    = 32,
  parameter int MAX_PARENTS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    op_i,
  input  logic [kdb_pkg::AttW-1:0]      first_att_i,
  input  logic [kdb_pkg::AttW-1:0]      second_att_i,
  input  logic [kdb_pkg::ScoreW-1:0]    score_value_i,
  input  logic                          cfg_we_i,
  input  logic [kdb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [kdb_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          result_valid_o,
  output logic [kdb_pkg::AttW-1:0]      child_att_o,
  output logic [2:0]                    parent_count_o,
  output logic [kdb_pkg::AttW-1:0]      parent_0_o,
  output logic [kdb_pkg::AttW-1:0]      parent_1_o,
  output logic [kdb_pkg::AttW-1:0]      parent_2_o,
  output logic [kdb_pkg::AttW-1:0]      parent_3_o,
  output logic                          last_o
);
  import kdb_pkg::*;

  localparam int AW = $clog2(MAX_ATTS);
  localparam int NW = $clog2(MAX_ATTS + 1);
  localparam int CW = $clog2(MAX_ATTS * MAX_ATTS);
  localparam int PS = (MAX_PARENTS < OutSlots) ? MAX_PARENTS : OutSlots;
  localparam int LW = $clog2(PS + 1);

  kdb_state_e state_q, state_d;

  logic [2:0]  k_q;
  logic [5:0]  num_q;
  logic [NW-1:0] i_q, i_d, j_q, j_d, p_q, p_d, q_q, q_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [ScoreW-1:0] si_q, si_d;
  logic [AW-1:0] child_q, child_d, cand_q, cand_d;
  logic [LW-1:0] len_q, len_d;
  logic [AW-1:0] ws_q [PS];
  logic [AW-1:0] ws_d [PS];
  logic [ScoreW-1:0] wsc_q [PS];
  logic [ScoreW-1:0] wsc_d [PS];

  // Memories.
  logic [ScoreW-1:0] score_mem [MAX_ATTS];
  logic [ScoreW-1:0] cond_mem [MAX_ATTS*MAX_ATTS];
  logic [AW-1:0]     rank_mem [MAX_ATTS];
  logic [ScoreW-1:0] score_rd_q, cond_rd_q;
  logic [AW-1:0]     rank_rd_q;
  logic [AW-1:0]     score_ra, rank_ra, rank_wa;
  logic [CW-1:0]     cond_ra, cond_wa;
  logic              score_we, cond_we, rank_we;

  logic [NW-1:0] n_eff;
  logic [LW-1:0] k_eff;
  logic          accept;
  logic [AW-1:0] a_idx, b_idx;
  logic          a_ok, b_ok;

  assign accept = start_i && (state_q == StIdle);
  assign busy_o = (state_q != StIdle);
  assign a_idx  = AW'(first_att_i);
  assign b_idx  = AW'(second_att_i);
  assign a_ok   = (32'(first_att_i) < MAX_ATTS);
  assign b_ok   = (32'(second_att_i) < MAX_ATTS);
  assign n_eff  = (32'(num_q) > MAX_ATTS) ? NW'(MAX_ATTS) : NW'(num_q);

  always_comb begin
    if (k_q == 3'd0) begin
      k_eff = LW'(1);
    end else if (32'(k_q) > PS) begin
      k_eff = LW'(PS);
    end else begin
      k_eff = LW'(k_q);
    end
  end

  assign score_we = accept && (op_i == OpLoadScore) && a_ok;
  assign cond_we  = accept && (op_i == OpLoadCond) && a_ok && b_ok;
  assign cond_wa  = CW'(int'(a_idx) * MAX_ATTS + int'(b_idx));
  assign score_ra = (state_q == StRankI) ? i_q[AW-1:0] : j_q[AW-1:0];
  assign rank_ra  = (state_q == StPickP) ? p_q[AW-1:0] : q_q[AW-1:0];
  assign rank_we  = (state_q == StRankW);
  assign rank_wa  = cnt_q;
  assign cond_ra  = CW'(int'(rank_rd_q) * MAX_ATTS + int'(child_q));

  always_ff @(posedge clk_i) begin
    if (score_we) begin
      score_mem[a_idx] <= score_value_i;
    end
    score_rd_q <= score_mem[score_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cond_we) begin
      cond_mem[cond_wa] <= score_value_i;
    end
    cond_rd_q <= cond_mem[cond_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      rank_mem[rank_wa] <= i_q[AW-1:0];
    end
    rank_rd_q <= rank_mem[rank_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= 3'd1;
      num_q <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKParents: k_q   <= cfg_data_i[2:0];
        CfgNumAtts:  num_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Insertion of the current candidate into the ordered parent list.
  logic [LW-1:0] ins;
  logic [LW-1:0] new_len;
  logic [AW-1:0] ext [PS];
  logic [ScoreW-1:0] exts [PS];

  always_comb begin
    for (int s = 0; s < PS; s++) begin
      ext[s]  = ws_q[s];
      exts[s] = wsc_q[s];
    end
    new_len = len_q;
    if (len_q < k_eff) begin
      for (int s = 0; s < PS; s++) begin
        if (LW'(s) == len_q) begin
          ext[s]  = cand_q;
          exts[s] = cond_rd_q;
        end
      end
      new_len = len_q + LW'(1);
    end
    ins = LW'(PS);
    for (int s = PS - 1; s >= 0; s--) begin
      if ((LW'(s) < len_q) && (cond_rd_q > wsc_q[s])) begin
        ins = LW'(s);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    i_d = i_q;
    j_d = j_q;
    p_d = p_q;
    q_d = q_q;
    cnt_d = cnt_q;
    si_d = si_q;
    child_d = child_q;
    cand_d = cand_q;
    len_d = len_q;
    for (int s = 0; s < PS; s++) begin
      ws_d[s]  = ws_q[s];
      wsc_d[s] = wsc_q[s];
    end
    case (state_q)
      StIdle: begin
        if (accept && (op_i == OpBuild) && (n_eff != '0)) begin
          i_d = '0;
          state_d = StRankI;
        end
      end
      StRankI: state_d = StRankIc;
      StRankIc: begin
        si_d = score_rd_q;
        j_d = '0;
        cnt_d = '0;
        state_d = StRankJ;
      end
      StRankJ: state_d = StRankJc;
      StRankJc: begin
        if ((score_rd_q > si_q) || ((score_rd_q == si_q) && (j_q < i_q))) begin
          cnt_d = cnt_q + AW'(1);
        end
        if (j_q == n_eff - NW'(1)) begin
          state_d = StRankW;
        end else begin
          j_d = j_q + NW'(1);
          state_d = StRankJ;
        end
      end
      StRankW: begin
        if (i_q == n_eff - NW'(1)) begin
          p_d = '0;
          state_d = StPickP;
        end else begin
          i_d = i_q + NW'(1);
          state_d = StRankI;
        end
      end
      StPickP: state_d = StPickPc;
      StPickPc: begin
        child_d = rank_rd_q;
        q_d = '0;
        len_d = '0;
        for (int s = 0; s < PS; s++) begin
          ws_d[s] = '0;
        end
        state_d = (p_q == '0) ? StEmit : StPickQ;
      end
      StPickQ: state_d = StPickQc;
      StPickQc: begin
        // The conditional score read is issued from the rank word this cycle.
        cand_d = rank_rd_q;
        state_d = StPickQu;
      end
      StPickQu: begin
        len_d = new_len;
        for (int s = 0; s < PS; s++) begin
          if (LW'(s) == ins) begin
            ws_d[s]  = cand_q;
            wsc_d[s] = cond_rd_q;
          end else if ((LW'(s) > ins) && (LW'(s) < new_len) && (s > 0)) begin
            ws_d[s]  = ext[(s > 0) ? s - 1 : 0];
            wsc_d[s] = exts[(s > 0) ? s - 1 : 0];
          end else begin
            ws_d[s]  = ext[s];
            wsc_d[s] = exts[s];
          end
        end
        if (q_q == p_q - NW'(1)) begin
          state_d = StEmit;
        end else begin
          q_d = q_q + NW'(1);
          state_d = StPickQ;
        end
      end
      StEmit: begin
        if (p_q == n_eff - NW'(1)) begin
          state_d = StIdle;
        end else begin
          p_d = p_q + NW'(1);
          state_d = StPickP;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q <= '0;
      j_q <= '0;
      p_q <= '0;
      q_q <= '0;
      cnt_q <= '0;
      len_q <= '0;
      for (int s = 0; s < PS; s++) begin
        ws_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;
      i_q <= i_d;
      j_q <= j_d;
      p_q <= p_d;
      q_q <= q_d;
      cnt_q <= cnt_d;
      len_q <= len_d;
      for (int s = 0; s < PS; s++) begin
        ws_q[s] <= ws_d[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    si_q <= si_d;
    child_q <= child_d;
    cand_q <= cand_d;
    for (int s = 0; s < PS; s++) begin
      wsc_q[s] <= wsc_d[s];
    end
  end

  logic [AttW-1:0] par_w [OutSlots];

  for (genvar g = 0; g < OutSlots; g++) begin : g_slot
    if (g < PS) begin : g_used
      assign par_w[g] = AttW'(ws_q[g]);
    end else begin : g_unused
      assign par_w[g] = '0;
    end
  end

  assign result_valid_o = (state_q == StEmit);
  assign child_att_o    = AttW'(child_q);
  assign parent_count_o = 3'(len_q);
  assign parent_0_o     = par_w[0];
  assign parent_1_o     = par_w[1];
  assign parent_2_o     = par_w[2];
  assign parent_3_o     = par_w[3];
  assign last_o         = (state_q == StEmit) && (p_q == n_eff - NW'(1));

  a_valid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result word outside a build");
  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |=> !busy_o) else $error("build did not end after last word");
  a_count_k : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (parent_count_o <= 3'(k_eff))) else $error("too many parents");
  a_root_bare : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (p_q == '0)) |-> (parent_count_o == 3'd0))
    else $error("root word carries parents");

endmodule
